@@ rtl/fld_pkg.sv @@
// ----------------------------------------------------------------------------
// fld_pkg
// Shared constants and types for the framebuffer line drawer.
// ----------------------------------------------------------------------------
package fld_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int COORD_BITS    = 12;

    localparam int PAGE_COUNT  = SCREEN_HEIGHT / 8;
    localparam int STORE_DEPTH = SCREEN_WIDTH * PAGE_COUNT;
    localparam int COL_BITS    = $clog2(SCREEN_WIDTH);
    localparam int PAGE_BITS   = $clog2(PAGE_COUNT);
    localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
    localparam int ERR_BITS    = COORD_BITS + 2;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [ERR_BITS-1:0]   t_err;
    typedef logic [ADDR_BITS-1:0]         t_addr;
    typedef logic [7:0]                   t_byte;

    typedef enum logic [1:0] {
        FUNC_DRAW  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2
    } t_func;

endpackage

@@ rtl/fld_ram.sv @@
// ----------------------------------------------------------------------------
// fld_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/framebuffer_line_drawer.sv @@
// ----------------------------------------------------------------------------
// framebuffer_line_drawer
// 128x64 one-bit framebuffer with a Bresenham line drawer, byte read and clear.
// ----------------------------------------------------------------------------
// After reset the block sweeps the 1024-byte framebuffer to zero, one byte per
// cycle, and holds o_ready low until the sweep is done. A line visits each
// point in turn: an on-screen point is a read then a write of its framebuffer
// byte through the single RAM port pair (S_PLOT_RD, then S_PLOT_WR), and an
// off-screen point is stepped past without a write; a clear sweeps the whole
// framebuffer to zero. Each
// accepted word returns exactly one result word, which is zero except for a
// read, and the block is busy until that result is placed in its output
// register.
// ----------------------------------------------------------------------------
module framebuffer_line_drawer
    import fld_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_func,
    input  logic [COORD_BITS-1:0] i_x_start,
    input  logic [COORD_BITS-1:0] i_y_start,
    input  logic [COORD_BITS-1:0] i_x_end,
    input  logic [COORD_BITS-1:0] i_y_end,
    input  logic                  i_set_pixels,
    input  logic [2:0]            i_read_page,
    input  logic [6:0]            i_read_column,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_read_data
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_PLOT_RD,
        S_PLOT_WR,
        S_READ,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    t_addr  r_clr_addr, n_clr_addr;
    t_coord r_x, n_x, r_y, n_y, r_xb, n_xb, r_yb, n_yb;
    t_err   r_dx, n_dx, r_dy, n_dy, r_err, n_err;
    logic   r_sx_neg, n_sx_neg, r_sy_neg, n_sy_neg, r_set, n_set;
    t_byte  r_res, n_res;
    logic   r_out_valid, n_out_valid;
    t_byte  r_read_data, n_read_data;

    logic   ram_we;
    t_addr  ram_waddr, ram_raddr;
    t_byte  ram_wdata, ram_rdata;

    logic   accept, push, on_screen, at_end, step_x, step_y;
    t_addr  pix_addr;
    t_byte  pix_mask;
    t_err   ext_xa, ext_ya, ext_xb, ext_yb, diff_x, diff_y, abs_x, abs_y;

    fld_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_read_data = r_read_data;
    assign accept      = i_valid && o_ready;
    assign push        = (r_state == S_EMIT) && (!r_out_valid || i_ready);

    always_comb begin
        ext_xa = t_err'($signed(i_x_start));
        ext_ya = t_err'($signed(i_y_start));
        ext_xb = t_err'($signed(i_x_end));
        ext_yb = t_err'($signed(i_y_end));
        diff_x = ext_xb - ext_xa;
        diff_y = ext_yb - ext_ya;
        abs_x  = diff_x[ERR_BITS-1] ? -diff_x : diff_x;
        abs_y  = diff_y[ERR_BITS-1] ? -diff_y : diff_y;

        on_screen = (r_x >= 0) && (r_x < t_coord'(SCREEN_WIDTH))
                 && (r_y >= 0) && (r_y < t_coord'(SCREEN_HEIGHT));
        pix_addr  = {r_y[PAGE_BITS+2:3], r_x[COL_BITS-1:0]};
        pix_mask  = t_byte'(1) << r_y[2:0];
        at_end    = (r_x == r_xb) && (r_y == r_yb);
        step_x    = r_err > -r_dx;
        step_y    = r_err < r_dy;
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_x         = r_x;
        n_y         = r_y;
        n_xb        = r_xb;
        n_yb        = r_yb;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_err       = r_err;
        n_sx_neg    = r_sx_neg;
        n_sy_neg    = r_sy_neg;
        n_set       = r_set;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_read_data = r_read_data;
        ram_we      = 1'b0;
        ram_waddr   = pix_addr;
        ram_wdata   = r_set ? (ram_rdata | pix_mask) : (ram_rdata & ~pix_mask);
        ram_raddr   = pix_addr;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_INIT, S_CLEAR: begin
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + t_addr'(1);
                if (r_clr_addr == t_addr'(STORE_DEPTH - 1)) begin
                    n_state = (r_state == S_INIT) ? S_IDLE : S_EMIT;
                end
            end
            S_IDLE: begin
                ram_raddr = {i_read_page[PAGE_BITS-1:0], i_read_column[COL_BITS-1:0]};
                if (accept) begin
                    n_res = '0;
                    case (i_func)
                        FUNC_DRAW: begin
                            n_x      = $signed(i_x_start);
                            n_y      = $signed(i_y_start);
                            n_xb     = $signed(i_x_end);
                            n_yb     = $signed(i_y_end);
                            n_dx     = abs_x;
                            n_dy     = abs_y;
                            n_sx_neg = !(ext_xa < ext_xb);
                            n_sy_neg = !(ext_ya < ext_yb);
                            n_set    = i_set_pixels;
                            n_err    = (abs_x > abs_y) ? (abs_x >>> 1) : -(abs_y >>> 1);
                            n_state  = S_PLOT_RD;
                        end
                        FUNC_READ: begin
                            if ((int'(i_read_page) < PAGE_COUNT)
                                && (int'(i_read_column) < SCREEN_WIDTH)) begin
                                n_state = S_READ;
                            end else begin
                                n_state = S_EMIT;
                            end
                        end
                        FUNC_CLEAR: begin
                            n_clr_addr = '0;
                            n_state    = S_CLEAR;
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_PLOT_RD, S_PLOT_WR: begin
                if (r_state == S_PLOT_RD && on_screen) begin
                    n_state = S_PLOT_WR;
                end else begin
                    ram_we = (r_state == S_PLOT_WR);
                    if (at_end) begin
                        n_state = S_EMIT;
                    end else begin
                        n_err = r_err - (step_x ? r_dy : t_err'(0))
                                      + (step_y ? r_dx : t_err'(0));
                        if (step_x) begin
                            n_x = r_sx_neg ? r_x - t_coord'(1) : r_x + t_coord'(1);
                        end
                        if (step_y) begin
                            n_y = r_sy_neg ? r_y - t_coord'(1) : r_y + t_coord'(1);
                        end
                        n_state = S_PLOT_RD;
                    end
                end
            end
            S_READ: begin
                n_res   = ram_rdata;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (push) begin
                    n_out_valid = 1'b1;
                    n_read_data = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
        r_x         <= n_x;
        r_y         <= n_y;
        r_xb        <= n_xb;
        r_yb        <= n_yb;
        r_dx        <= n_dx;
        r_dy        <= n_dy;
        r_err       <= n_err;
        r_sx_neg    <= n_sx_neg;
        r_sy_neg    <= n_sy_neg;
        r_set       <= n_set;
        r_res       <= n_res;
        r_read_data <= n_read_data;
    end

endmodule
